[rtl/rlct_pkg.sv]
// Shared types and constants for the recursive lock count table.
// No dependencies; imported by every module of the block.
package rlct_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int KEY_WIDTH   = 48;
  localparam int COUNT_WIDTH = 16;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

  // request and result queue geometry (two entries each)
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_SATURATED = 2'd3
  } status_e;

  typedef struct packed {
    logic                 release_op;
    logic [KEY_WIDTH-1:0] key;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [COUNT_WIDTH-1:0] count;
    logic [OCC_W-1:0]     used;
  } res_t;

endpackage

[rtl/recursive_lock_count_table_unit.sv]
// Top level of the recursive lock count table.
// Instantiates rlct_front and rlct_back; depends on rlct_pkg.
//
//  channel   | direction | handshake        | payload
//  ----------+-----------+------------------+-----------------------------------
//  request   | in        | push / full      | req_type_i, lock_id_i
//  result    | out       | pop / empty      | status_o, hold_count_o, entries_used_o
//
// One request per cycle sustained unless the result side stalls; each
// request yields exactly one result, passing the request queue, then the
// parallel key compare and update in the back end, then the result queue.
// rst_ni clears the table occupancy and both queues; no clearing pass.
// The two-deep request and result queues let either side stall alone; a
// stalled result side fills its queue, then the request queue, then full.
module recursive_lock_count_table_unit
  import rlct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        req_type_i,
  input  logic [47:0] lock_id_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [15:0] hold_count_o,
  output logic [4:0]  entries_used_o
);

  req_t req;
  logic req_valid;
  logic take;
  res_t res;

  // front: accept and trim key
  rlct_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .req_type_i  (req_type_i),
    .lock_id_i   (lock_id_i),
    .req_valid_o (req_valid),
    .req_o       (req),
    .take_i      (take)
  );

  // back: table lookup, update and result queue
  rlct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_i       (req),
    .take_o      (take),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign status_o       = res.status;
  assign hold_count_o   = res.count;
  assign entries_used_o = res.used;

endmodule

[rtl/rlct_front.sv]
// Front end: takes requests, strips the key to the table width and
// queues them for the back end. Depends on rlct_pkg.
module rlct_front
  import rlct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic        req_type_i,
  input  logic [47:0] lock_id_i,
  output logic        req_valid_o,
  output req_t        req_o,
  input  logic        take_i
);

  req_t               buf_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               push_acc, take_acc;
  req_t               req_in;

  assign full_o      = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign req_valid_o = (cnt_q != '0);
  assign push_acc    = push_i & ~full_o;
  assign take_acc    = take_i & req_valid_o;

  // classify: release flag and key trimmed to table width
  assign req_in.release_op = req_type_i;
  assign req_in.key        = lock_id_i[KEY_WIDTH-1:0];

  assign req_o = buf_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_acc && !take_acc) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (!push_acc && take_acc) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_acc) begin
        wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
      end
      if (take_acc) begin
        rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_acc) begin
      buf_q[wr_ptr_q] <= req_in;
    end
  end

endmodule

[rtl/rlct_back.sv]
// Back end: key table with parallel match, count update, swap-last removal,
// and the result queue. Depends on rlct_pkg.
module rlct_back
  import rlct_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  req_t req_i,
  output logic take_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  logic [KEY_WIDTH-1:0]   key_q [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] cnt_q [TABLE_DEPTH];
  logic [OCC_W-1:0]       occ_q, occ_d;

  logic [TABLE_DEPTH-1:0] match;
  logic                   hit;
  logic [IDX_W-1:0]       slot;
  logic [COUNT_WIDTH-1:0] cnt_hit;
  logic [OCC_W-1:0]       occ_last;
  logic [IDX_W-1:0]       last_idx;
  logic                   tbl_full;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_idx;
  logic [KEY_WIDTH-1:0]   wr_key;
  logic [COUNT_WIDTH-1:0] wr_cnt;
  res_t                   res_d;

  res_t               oq_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] oq_wr_q, oq_rd_q;
  logic [Q_CNT_W-1:0] oq_cnt_q, oq_cnt_d;
  logic               pop_acc;

  // valid entries only; unwritten slots never take part
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match[i] = (OCC_W'(i) < occ_q) && (key_q[i] == req_i.key);
    end
  end

  always_comb begin
    slot = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        slot = IDX_W'(i);
      end
    end
  end

  assign hit      = |match;
  assign cnt_hit  = cnt_q[slot];
  assign occ_last = occ_q - OCC_W'(1);
  assign last_idx = occ_last[IDX_W-1:0];
  assign tbl_full = (occ_q == OCC_W'(TABLE_DEPTH));

  assign take_o = req_valid_i && (oq_cnt_q != Q_CNT_W'(Q_DEPTH));

  always_comb begin
    wr_en        = 1'b0;
    wr_idx       = slot;
    wr_key       = req_i.key;
    wr_cnt       = cnt_hit;
    occ_d        = occ_q;
    res_d.status = ST_OK;
    res_d.count  = '0;
    if (!req_i.release_op) begin
      if (!hit) begin
        if (!tbl_full) begin
          wr_en       = 1'b1;
          wr_idx      = occ_q[IDX_W-1:0];
          wr_cnt      = COUNT_WIDTH'(1);
          occ_d       = occ_q + OCC_W'(1);
          res_d.count = COUNT_WIDTH'(1);
        end else begin
          res_d.status = ST_FULL;
        end
      end else if (cnt_hit == COUNT_MAX) begin
        res_d.status = ST_SATURATED;
        res_d.count  = COUNT_MAX;
      end else begin
        wr_en       = 1'b1;
        wr_cnt      = cnt_hit + COUNT_WIDTH'(1);
        res_d.count = cnt_hit + COUNT_WIDTH'(1);
      end
    end else begin
      if (!hit) begin
        res_d.status = ST_NOT_FOUND;
      end else if (cnt_hit > COUNT_WIDTH'(1)) begin
        wr_en       = 1'b1;
        wr_cnt      = cnt_hit - COUNT_WIDTH'(1);
        res_d.count = cnt_hit - COUNT_WIDTH'(1);
      end else begin
        // last entry fills the hole
        wr_en  = 1'b1;
        wr_key = key_q[last_idx];
        wr_cnt = cnt_q[last_idx];
        occ_d  = occ_last;
      end
    end
    res_d.used = occ_d;
  end

  // result queue
  assign empty_o = (oq_cnt_q == '0);
  assign pop_acc = pop_i & ~empty_o;
  assign res_o   = oq_q[oq_rd_q];

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (take_o && !pop_acc) begin
      oq_cnt_d = oq_cnt_q + Q_CNT_W'(1);
    end else if (!take_o && pop_acc) begin
      oq_cnt_d = oq_cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      if (take_o) begin
        occ_q   <= occ_d;
        oq_wr_q <= oq_wr_q + Q_PTR_W'(1);
      end
      if (pop_acc) begin
        oq_rd_q <= oq_rd_q + Q_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && wr_en) begin
      key_q[wr_idx] <= wr_key;
      cnt_q[wr_idx] <= wr_cnt;
    end
    if (take_o) begin
      oq_q[oq_wr_q] <= res_d;
    end
  end

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(TABLE_DEPTH))
    else $error("occupancy beyond table depth");

  a_unique_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i |-> $countones(match) <= 1)
    else $error("duplicate key in table");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && req_i.release_op && hit && cnt_hit <= COUNT_WIDTH'(1))
      |=> occ_q == $past(occ_q) - OCC_W'(1))
    else $error("removal did not lower occupancy");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take_o && res_d.status == ST_FULL) |-> tbl_full)
    else $error("table full reported with free slots");
`endif

endmodule
